// ===== hw/rtl/cc20_pkg.sv =====
package cc20_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned STATE_WORDS = 16;
  localparam int unsigned LANES = 4;
  localparam int unsigned ROUNDS = 20;
  localparam int unsigned ROUND_W = $clog2(ROUNDS);
  localparam int unsigned ITEM_BYTES = 8;
  localparam int unsigned ITEM_W = 8 * ITEM_BYTES;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned ITEMS_PER_BLOCK = (STATE_WORDS * WORD_W) / ITEM_W;
  localparam int unsigned POS_W = $clog2(ITEMS_PER_BLOCK);
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [STATE_WORDS-1:0][WORD_W-1:0] block_t;

  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;
  localparam word_t COUNTER_RESET = 32'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_NONCE_L = 3'd4,
    REG_NONCE_H = 3'd5,
    REG_ICOUNT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  message_bytes;
    logic [COUNT_W-1:0] valid_bytes;
    logic               end_of_message;
  } msg_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  crypted_bytes;
    logic [COUNT_W-1:0] crypted_count;
    logic               crypted_last;
  } res_t;

  typedef struct packed {
    logic start;
    logic abort;
    logic take;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic full;
  } core_stat_t;

  function automatic word_t rotl(input word_t x, input int unsigned s);
    rotl = (x << s) | (x >> (WORD_W - s));
  endfunction

endpackage

// ===== hw/rtl/cc20_qr.sv =====
module cc20_qr (
  input  cc20_pkg::word_t a,
  input  cc20_pkg::word_t b,
  input  cc20_pkg::word_t c,
  input  cc20_pkg::word_t d,
  output cc20_pkg::word_t a_out,
  output cc20_pkg::word_t b_out,
  output cc20_pkg::word_t c_out,
  output cc20_pkg::word_t d_out
);

  cc20_pkg::word_t a1, b1, c1, d1;

  always_comb begin
    a1 = a + b;
    d1 = cc20_pkg::rotl(d ^ a1, 16);
    c1 = c + d1;
    b1 = cc20_pkg::rotl(b ^ c1, 12);
    a_out = a1 + b1;
    d_out = cc20_pkg::rotl(d1 ^ a_out, 8);
    c_out = c1 + d_out;
    b_out = cc20_pkg::rotl(b1 ^ c_out, 7);
  end

endmodule

// ===== hw/rtl/cc20_core.sv =====
module cc20_core (
  input  logic                 clk,
  input  logic                 rst,
  input  cc20_pkg::core_ctrl_t ctrl,
  input  cc20_pkg::block_t     init_in,
  output cc20_pkg::core_stat_t stat,
  output cc20_pkg::block_t     block_out
);

  localparam logic [cc20_pkg::ROUND_W-1:0] LAST_ROUND =
    cc20_pkg::ROUND_W'(cc20_pkg::ROUNDS - 1);

  cc20_pkg::block_t x;
  cc20_pkg::block_t x_next;
  cc20_pkg::block_t init_r;
  logic [cc20_pkg::ROUND_W-1:0] rnd;
  logic busy;
  logic full;
  logic diag;

  logic [cc20_pkg::LANES-1:0][cc20_pkg::WORD_W-1:0] la, lb, lc, ld;
  logic [cc20_pkg::LANES-1:0][cc20_pkg::WORD_W-1:0] oa, ob, oc, od;

  assign diag = rnd[0];

  // Odd rounds work on the diagonals, so each lane shifts its b, c and d rows.
  for (genvar j = 0; j < cc20_pkg::LANES; j++) begin : g_lane
    localparam int unsigned L = cc20_pkg::LANES;
    assign la[j] = x[j];
    assign lb[j] = diag ? x[L + (j + 1) % L] : x[L + j];
    assign lc[j] = diag ? x[2 * L + (j + 2) % L] : x[2 * L + j];
    assign ld[j] = diag ? x[3 * L + (j + 3) % L] : x[3 * L + j];

    cc20_qr u_qr (
      .a(la[j]), .b(lb[j]), .c(lc[j]), .d(ld[j]),
      .a_out(oa[j]), .b_out(ob[j]), .c_out(oc[j]), .d_out(od[j])
    );

    assign x_next[j]         = oa[j];
    assign x_next[L + j]     = diag ? ob[(j + 3) % L] : ob[j];
    assign x_next[2 * L + j] = diag ? oc[(j + 2) % L] : oc[j];
    assign x_next[3 * L + j] = diag ? od[(j + 1) % L] : od[j];
  end

  for (genvar i = 0; i < cc20_pkg::STATE_WORDS; i++) begin : g_out
    assign block_out[i] = x[i] + init_r[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      full <= 1'b0;
      rnd  <= '0;
    end else if (ctrl.abort) begin
      busy <= 1'b0;
      full <= 1'b0;
      rnd  <= '0;
    end else begin
      if (ctrl.take) begin
        full <= 1'b0;
      end
      if (ctrl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == LAST_ROUND) begin
          busy <= 1'b0;
          full <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x      <= init_in;
      init_r <= init_in;
    end else if (busy) begin
      x <= x_next;
    end
  end

  assign stat.busy = busy;
  assign stat.full = full;

endmodule

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// Channel  Payload             Handshake            Transfer
// cfg      cfg_index/cfg_data  cfg_wen              one register write
// msg      msg_data            msg_valid/msg_stall  up to eight message bytes in
// res      res_data            res_valid/res_stall  up to eight crypted bytes out
//
// A keystream block takes 20 rounds, one round a cycle in four quarter-round lanes, and is
// then loaded into the buffer. The next block is computed while the current one serves
// eight transfers. After reset, a register write or the end of a message, the first item
// waits for a newly computed block. A result is registered and appears in the cycle after
// its input transfer. Reset is synchronous; a stalled result holds its register
// and stalls the input.
module chacha20_stream_cipher (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [cc20_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 msg_valid,
  output logic                                 msg_stall,
  input  cc20_pkg::msg_t                       msg_data,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output cc20_pkg::res_t                       res_data
);

  logic [63:0] key0, key1, key2, key3;
  logic [63:0] nonce_low;
  cc20_pkg::word_t nonce_high;
  cc20_pkg::word_t icount;
  cc20_pkg::word_t icount_next;
  cc20_pkg::word_t gen_counter;

  logic [cc20_pkg::ITEMS_PER_BLOCK-1:0][cc20_pkg::ITEM_W-1:0] ks_buf;
  logic ks_valid;
  logic [cc20_pkg::POS_W-1:0] pos;

  logic cfg_hit;
  logic msg_xfer;
  logic restart;
  logic load;
  logic [cc20_pkg::ITEM_W-1:0] ks_word;
  logic [cc20_pkg::COUNT_W-1:0] count;
  cc20_pkg::res_t res_next;

  cc20_pkg::core_ctrl_t ctrl;
  cc20_pkg::core_stat_t stat;
  cc20_pkg::block_t init_words;
  cc20_pkg::block_t blk;

  always_comb begin
    case (cfg_index)
      cc20_pkg::REG_KEY0, cc20_pkg::REG_KEY1, cc20_pkg::REG_KEY2, cc20_pkg::REG_KEY3,
      cc20_pkg::REG_NONCE_L, cc20_pkg::REG_NONCE_H, cc20_pkg::REG_ICOUNT: begin
        cfg_hit = cfg_wen;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  assign icount_next = (cfg_wen && cfg_index == cc20_pkg::REG_ICOUNT) ?
                       cfg_data[cc20_pkg::WORD_W-1:0] : icount;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0       <= '0;
      key1       <= '0;
      key2       <= '0;
      key3       <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
      icount     <= cc20_pkg::COUNTER_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        cc20_pkg::REG_KEY0:    key0 <= cfg_data;
        cc20_pkg::REG_KEY1:    key1 <= cfg_data;
        cc20_pkg::REG_KEY2:    key2 <= cfg_data;
        cc20_pkg::REG_KEY3:    key3 <= cfg_data;
        cc20_pkg::REG_NONCE_L: nonce_low <= cfg_data;
        cc20_pkg::REG_NONCE_H: nonce_high <= cfg_data[cc20_pkg::WORD_W-1:0];
        cc20_pkg::REG_ICOUNT:  icount <= cfg_data[cc20_pkg::WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign init_words[0]  = cc20_pkg::SIGMA0;
  assign init_words[1]  = cc20_pkg::SIGMA1;
  assign init_words[2]  = cc20_pkg::SIGMA2;
  assign init_words[3]  = cc20_pkg::SIGMA3;
  assign init_words[4]  = key0[31:0];
  assign init_words[5]  = key0[63:32];
  assign init_words[6]  = key1[31:0];
  assign init_words[7]  = key1[63:32];
  assign init_words[8]  = key2[31:0];
  assign init_words[9]  = key2[63:32];
  assign init_words[10] = key3[31:0];
  assign init_words[11] = key3[63:32];
  assign init_words[12] = gen_counter;
  assign init_words[13] = nonce_low[31:0];
  assign init_words[14] = nonce_low[63:32];
  assign init_words[15] = nonce_high;

  assign msg_stall = !(ks_valid && (!res_valid || !res_stall));
  assign msg_xfer  = msg_valid && !msg_stall;
  assign restart   = cfg_hit || (msg_xfer && msg_data.end_of_message);

  assign load = stat.full && !restart &&
                (!ks_valid ||
                 (msg_xfer && pos == cc20_pkg::POS_W'(cc20_pkg::ITEMS_PER_BLOCK - 1)));

  assign ctrl.abort = restart;
  assign ctrl.take  = load;
  assign ctrl.start = !restart && !stat.busy && (!stat.full || load);

  cc20_core u_core (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .init_in(init_words),
    .stat(stat),
    .block_out(blk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_valid    <= 1'b0;
      pos         <= '0;
      gen_counter <= cc20_pkg::COUNTER_RESET;
    end else if (restart) begin
      ks_valid    <= 1'b0;
      pos         <= '0;
      gen_counter <= icount_next;
    end else begin
      if (msg_xfer) begin
        pos <= pos + 1'b1;
        if (pos == cc20_pkg::POS_W'(cc20_pkg::ITEMS_PER_BLOCK - 1)) begin
          ks_valid <= 1'b0;
        end
      end
      if (load) begin
        ks_valid <= 1'b1;
      end
      if (ctrl.start) begin
        gen_counter <= gen_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int w = 0; w < cc20_pkg::ITEMS_PER_BLOCK; w++) begin
        ks_buf[w] <= {blk[2 * w + 1], blk[2 * w]};
      end
    end
  end

  assign ks_word = ks_buf[pos];

  always_comb begin
    count = (msg_data.valid_bytes > cc20_pkg::COUNT_W'(cc20_pkg::ITEM_BYTES)) ?
            cc20_pkg::COUNT_W'(cc20_pkg::ITEM_BYTES) : msg_data.valid_bytes;
    for (int i = 0; i < cc20_pkg::ITEM_BYTES; i++) begin
      if (cc20_pkg::COUNT_W'(i) < count) begin
        res_next.crypted_bytes[8 * i +: 8] = msg_data.message_bytes[8 * i +: 8] ^
                                             ks_word[8 * i +: 8];
      end else begin
        res_next.crypted_bytes[8 * i +: 8] = 8'h00;
      end
    end
    res_next.crypted_count = count;
    res_next.crypted_last  = msg_data.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (msg_xfer) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_xfer) begin
      res_data <= res_next;
    end
  end

  a_xfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    msg_xfer |=> res_valid)
    else $error("An input transfer did not produce a result.");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    msg_xfer && msg_data.end_of_message |=> !ks_valid && pos == '0)
    else $error("The end of a message did not restart the keystream.");

  a_core_state: assert property (@(posedge clk) disable iff (rst)
    !(stat.busy && stat.full))
    else $error("The block core is busy and full at once.");

  a_load_from_core: assert property (@(posedge clk) disable iff (rst)
    $rose(ks_valid) |-> $past(stat.full))
    else $error("The keystream buffer was loaded without a finished block.");

endmodule
